>>> hdl/hsvrgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
package hsvrgb_pkg;

  // Channel byte width and the 8-bit full scale
  localparam int unsigned CH_W     = 8;
  localparam int unsigned CH_MAX   = 255;

  // Width of the scaled rounding quotient before the divide by 255
  localparam int unsigned QUO_W    = 16;

  // Reciprocal of 255 in 16-bit fixed point (257 / 65536 just under 1/255)
  localparam int unsigned RECIP255 = 257;
  localparam int unsigned RECIP_SH = 16;

  // Hue sextant: which channel holds V and which holds p, q or t
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

endpackage

>>> hdl/hsv_to_rgb_converter_top.sv
// HSV to RGB pixel converter: five register stages, one item per clock.
// done_o pulses once an accepted item has passed stage 1, the term lanes and the output register.
// Throughput: one item per cycle; busy_o stays low, the pipeline never stalls.
// The three term lanes (p, q, t) each hold a multiply, a multiply and a
// reciprocal divide stage, set by one multiplier per stage.
// Reset clears only the valid bits; payload stages carry no reset.
module hsv_to_rgb_converter_top
  import hsvrgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [HUE_BITS-1:0] hue_i,
  input  logic [CH_W-1:0]     saturation_i,
  input  logic [CH_W-1:0]     brightness_i,
  input  logic [CH_W-1:0]     alpha_in_i,
  output logic                done_o,
  output logic [CH_W-1:0]     red_o,
  output logic [CH_W-1:0]     green_o,
  output logic [CH_W-1:0]     blue_o,
  output logic [CH_W-1:0]     alpha_out_o
);

  localparam int unsigned LANE_DEPTH = 3;

  logic                  accept;
  logic [HUE_BITS+2:0]   six;
  logic [HUE_BITS:0]     frac_ext;
  logic [HUE_BITS:0]     full_turn;

  // Stage 1 registers
  logic                  vld1_q;
  sector_e               sec1_q;
  logic [HUE_BITS:0]     frac1_q;
  logic [HUE_BITS:0]     rest1_q;
  logic [CH_W-1:0]       sat1_q;
  logic [CH_W-1:0]       val1_q;
  logic [CH_W-1:0]       alpha1_q;

  // Side pipeline alongside the term lanes
  logic [LANE_DEPTH-1:0] vld_q;
  sector_e               sec_q   [LANE_DEPTH];
  logic [CH_W-1:0]       val_q   [LANE_DEPTH];
  logic [CH_W-1:0]       alpha_q [LANE_DEPTH];

  logic [CH_W-1:0]       p_term;
  logic [CH_W-1:0]       q_term;
  logic [CH_W-1:0]       t_term;
  logic [CH_W-1:0]       vv;

  logic                  done_q;
  logic [CH_W-1:0]       red_q, red_d;
  logic [CH_W-1:0]       green_q, green_d;
  logic [CH_W-1:0]       blue_q, blue_d;
  logic [CH_W-1:0]       alpha_out_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Split six times the hue into sextant and fraction
  assign six       = ({3'b000, hue_i} << 2) + ({3'b000, hue_i} << 1);
  assign frac_ext  = {1'b0, six[HUE_BITS-1:0]};
  assign full_turn = (HUE_BITS+1)'(1) << HUE_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= accept;
    end
  end

  // Hold the stage 1 payload
  always_ff @(posedge clk_i) begin
    sec1_q   <= sector_e'(six[HUE_BITS+2:HUE_BITS]);
    frac1_q  <= frac_ext;
    rest1_q  <= full_turn - frac_ext;
    sat1_q   <= saturation_i;
    val1_q   <= brightness_i;
    alpha1_q <= alpha_in_i;
  end

  // Term lanes: p uses x = D, q uses x = F, t uses x = D - F
  hsvrgb_term #(.HUE_BITS(HUE_BITS)) u_term_p (
    .clk_i  (clk_i),
    .sat_i  (sat1_q),
    .val_i  (val1_q),
    .x_i    (full_turn),
    .term_o (p_term)
  );

  hsvrgb_term #(.HUE_BITS(HUE_BITS)) u_term_q (
    .clk_i  (clk_i),
    .sat_i  (sat1_q),
    .val_i  (val1_q),
    .x_i    (frac1_q),
    .term_o (q_term)
  );

  hsvrgb_term #(.HUE_BITS(HUE_BITS)) u_term_t (
    .clk_i  (clk_i),
    .sat_i  (sat1_q),
    .val_i  (val1_q),
    .x_i    (rest1_q),
    .term_o (t_term)
  );

  // Advance valid bits in step with the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LANE_DEPTH-2:0], vld1_q};
    end
  end

  // Delay sextant, value and alpha to meet the terms
  always_ff @(posedge clk_i) begin
    sec_q[0]   <= sec1_q;
    val_q[0]   <= val1_q;
    alpha_q[0] <= alpha1_q;
    for (int i = 1; i < LANE_DEPTH; i++) begin
      sec_q[i]   <= sec_q[i-1];
      val_q[i]   <= val_q[i-1];
      alpha_q[i] <= alpha_q[i-1];
    end
  end

  // Route V, p, q, t to the channels by sextant
  assign vv = val_q[LANE_DEPTH-1];

  always_comb begin
    unique case (sec_q[LANE_DEPTH-1])
      SEC_RED_YEL: begin
        red_d = vv;     green_d = t_term; blue_d = p_term;
      end
      SEC_YEL_GRN: begin
        red_d = q_term; green_d = vv;     blue_d = p_term;
      end
      SEC_GRN_CYN: begin
        red_d = p_term; green_d = vv;     blue_d = t_term;
      end
      SEC_CYN_BLU: begin
        red_d = p_term; green_d = q_term; blue_d = vv;
      end
      SEC_BLU_MAG: begin
        red_d = t_term; green_d = p_term; blue_d = vv;
      end
      default: begin
        red_d = vv;     green_d = p_term; blue_d = q_term;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LANE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    red_q       <= red_d;
    green_q     <= green_d;
    blue_q      <= blue_d;
    alpha_out_q <= alpha_q[LANE_DEPTH-1];
  end

  assign done_o      = done_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_out_o = alpha_out_q;

  // A result always traces back to an accepted item
  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 5))
    else $error("result without an accepted item");

  // Alpha travels with its own item
  a_alpha_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (alpha_out_o == $past(alpha_in_i, 5)))
    else $error("alpha out of step with its item");

  // No channel exceeds V, and one channel carries V
  a_value_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (red_o <= $past(brightness_i, 5)) && (green_o <= $past(brightness_i, 5)) &&
               (blue_o <= $past(brightness_i, 5)) &&
               ((red_o == $past(brightness_i, 5)) || (green_o == $past(brightness_i, 5)) ||
                (blue_o == $past(brightness_i, 5))))
    else $error("channel outside value bound");

  // Zero saturation gives grey at V
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(saturation_i, 5) == '0)) |->
      (red_o == green_o) && (green_o == blue_o) && (blue_o == $past(brightness_i, 5)))
    else $error("zero saturation not grey");

endmodule

>>> hdl/hsvrgb_term.sv
// Three-stage lane for one rounded term round(V * (255*D - S*x) / (255*D)).
module hsvrgb_term
  import hsvrgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [CH_W-1:0]       sat_i,
  input  logic [CH_W-1:0]       val_i,
  input  logic [HUE_BITS:0]     x_i,
  output logic [CH_W-1:0]       term_o
);

  localparam int unsigned M_W = HUE_BITS + 8;
  localparam int unsigned P_W = HUE_BITS + 16;

  // 255 * D and the round-half-up offset 127.5 * D
  localparam logic [M_W-1:0] FULL_SCALE = M_W'(CH_MAX) << HUE_BITS;
  localparam logic [P_W-1:0] ROUND_OFS  = P_W'(CH_MAX) << (HUE_BITS - 1);

  logic [M_W-1:0]    sx_q;
  logic [CH_W-1:0]   val_a_q;
  logic [P_W-1:0]    prod_q;
  logic [QUO_W-1:0]  quo_q;
  logic [CH_W-1:0]   est_q;

  logic [M_W-1:0]    sx_d;
  logic [M_W-1:0]    diff;
  logic [P_W-1:0]    prod_d;
  logic [P_W-1:0]    rsum;
  logic [QUO_W-1:0]  quo_d;
  logic [QUO_W+8:0]  recip_prod;
  logic [CH_W-1:0]   est_d;
  logic [QUO_W-1:0]  rem;

  // Stage A: scale the hue offset by saturation
  assign sx_d = M_W'(sat_i) * M_W'(x_i);

  // Stage B: complement against full scale, then scale by value
  assign diff   = FULL_SCALE - sx_q;
  assign prod_d = P_W'(val_a_q) * P_W'(diff);

  // Stage C: round, drop the 2^HUE_BITS scale, estimate the divide by 255
  assign rsum       = prod_q + ROUND_OFS;
  assign quo_d      = rsum[HUE_BITS +: QUO_W];
  assign recip_prod = (QUO_W+9)'(quo_d) * (QUO_W+9)'(RECIP255);
  assign est_d      = recip_prod[RECIP_SH +: CH_W];

  // Correct the estimate, which may sit one below the true quotient
  assign rem    = quo_q - (QUO_W'(est_q) * QUO_W'(CH_MAX));
  assign term_o = (rem >= QUO_W'(CH_MAX)) ? est_q + CH_W'(1) : est_q;

  // Advance the lane every cycle
  always_ff @(posedge clk_i) begin
    sx_q    <= sx_d;
    val_a_q <= val_i;
    prod_q  <= prod_d;
    quo_q   <= quo_d;
    est_q   <= est_d;
  end

endmodule
